### rtl/seven_segment_display_formatter_macros.svh
// assertion macros for the seven-segment display formatter
// used by the top level only; compiled out when SYNTHESIS is defined
`ifndef SEVEN_SEGMENT_DISPLAY_FORMATTER_MACROS_SVH
`define SEVEN_SEGMENT_DISPLAY_FORMATTER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SSDF_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SSDF_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSDF_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define SSDF_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/ssdf_pkg.sv
// shared types, constants and segment tables of the display formatter
// no dependencies
`default_nettype none

package ssdf_pkg;

  localparam int DIGITS = 4;

  // item modes (code three behaves as number mode)
  localparam logic [1:0] MODE_NUMBER = 2'd0;
  localparam logic [1:0] MODE_STRING = 2'd1;
  localparam logic [1:0] MODE_LABEL  = 2'd2;

  // controller commands
  localparam logic [7:0] CMD_CONTROL = 8'h48;
  localparam logic [7:0] CMD_DIG0    = 8'h68;
  localparam logic [7:0] CMD_DIG1    = 8'h6A;
  localparam logic [7:0] CMD_DIG2    = 8'h6C;
  localparam logic [7:0] CMD_DIG3    = 8'h6E;

  // segment and control bytes
  localparam logic [7:0] SEG_BLANK = 8'h00;
  localparam logic [7:0] SEG_MINUS = 8'h40;
  localparam logic [7:0] SEG_POINT = 8'h80;
  localparam logic [7:0] CTRL_OFF  = 8'h00;
  localparam logic [7:0] CTRL_ON   = 8'h01;

  // ascii codes
  localparam logic [7:0] CHR_LO_A  = 8'h61;
  localparam logic [7:0] CHR_LO_Z  = 8'h7A;
  localparam logic [7:0] CHR_UP_A  = 8'h41;
  localparam logic [7:0] CHR_UP_Z  = 8'h5A;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_DOT   = 8'h2E;

  localparam logic [13:0] NUM_MAX = 14'd9999;

  typedef logic [DIGITS-1:0][7:0] seg_row_t;
  typedef logic [DIGITS-1:0][7:0] char_row_t;

  // per-lane display selection
  typedef struct packed {
    logic use_char;
    logic use_digit;
  } lane_ctl_t;

  // output sequencer states: idle, then one per beat
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_CTRL,
    SEQ_DIG0,
    SEQ_DIG1,
    SEQ_DIG2,
    SEQ_DIG3
  } seq_state_t;

  // digit patterns 0..9 then letters a..z
  function automatic logic [7:0] seg_pattern(input logic [5:0] idx);
    logic [7:0] s;
    case (idx)
      6'd0:  s = 8'h3F;  6'd1:  s = 8'h06;  6'd2:  s = 8'h5B;  6'd3:  s = 8'h4F;
      6'd4:  s = 8'h66;  6'd5:  s = 8'h6D;  6'd6:  s = 8'h7D;  6'd7:  s = 8'h07;
      6'd8:  s = 8'h7F;  6'd9:  s = 8'h6F;  6'd10: s = 8'h77;  6'd11: s = 8'h7C;
      6'd12: s = 8'h39;  6'd13: s = 8'h5E;  6'd14: s = 8'h79;  6'd15: s = 8'h71;
      6'd16: s = 8'h3D;  6'd17: s = 8'h76;  6'd18: s = 8'h0F;  6'd19: s = 8'h0E;
      6'd20: s = 8'h75;  6'd21: s = 8'h38;  6'd22: s = 8'h37;  6'd23: s = 8'h54;
      6'd24: s = 8'h5C;  6'd25: s = 8'h73;  6'd26: s = 8'h67;  6'd27: s = 8'h31;
      6'd28: s = 8'h49;  6'd29: s = 8'h78;  6'd30: s = 8'h3E;  6'd31: s = 8'h1C;
      6'd32: s = 8'h7E;  6'd33: s = 8'h64;  6'd34: s = 8'h6E;  6'd35: s = 8'h59;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // ascii character to segment byte; capitals light the point
  function automatic logic [7:0] char_to_seg(input logic [7:0] c);
    logic [7:0] s;
    s = SEG_BLANK;
    if (c >= CHR_LO_A && c <= CHR_LO_Z) begin
      s = seg_pattern(6'(c - CHR_LO_A) + 6'd10);
    end else if (c >= CHR_UP_A && c <= CHR_UP_Z) begin
      s = seg_pattern(6'(c - CHR_UP_A) + 6'd10) | SEG_POINT;
    end else if (c >= CHR_ZERO && c <= CHR_NINE) begin
      s = seg_pattern(6'(c - CHR_ZERO));
    end else if (c == CHR_MINUS) begin
      s = SEG_MINUS;
    end else if (c == CHR_DOT) begin
      s = SEG_POINT;
    end
    return s;
  endfunction

  // reciprocal of the decimal weight of a position, scaled by 2^24
  function automatic logic [24:0] lane_recip(input logic [1:0] pos);
    logic [24:0] r;
    case (pos)
      2'd0:    r = 25'd16778;
      2'd1:    r = 25'd167773;
      2'd2:    r = 25'd1677722;
      default: r = 25'd16777216;
    endcase
    return r;
  endfunction

  // a number-mode digit shows once the value reaches this limit
  function automatic logic [13:0] lane_blank_limit(input logic [1:0] pos);
    logic [13:0] l;
    case (pos)
      2'd0:    l = 14'd1000;
      2'd1:    l = 14'd100;
      2'd2:    l = 14'd10;
      default: l = 14'd0;
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

### rtl/ssdf_lane.sv
// one display position: decimal digit extraction and segment encoding
// depends on ssdf_pkg
`default_nettype none

module ssdf_lane
  import ssdf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        adv,
  input  wire logic [1:0]  lane_pos,
  input  wire logic [1:0]  mode,
  input  wire logic [2:0]  length,
  input  wire logic [13:0] v,
  input  wire logic [7:0]  ch,
  output logic      [7:0]  seg
);

  logic [38:0] prod4;
  logic [13:0] q4_nxt, q4_r;
  lane_ctl_t   ctl4_nxt, ctl4_r;
  logic [7:0]  ch4_r;

  logic [26:0] prod5;
  logic [9:0]  t5_nxt, t5_r;
  logic [13:0] q5_r;
  lane_ctl_t   ctl5_r;
  logic [7:0]  ch5_r;

  logic [13:0] diff;
  logic [3:0]  digit;

  // quotient by the position weight
  always_comb begin
    prod4  = 39'(v) * 39'(lane_recip(lane_pos));
    q4_nxt = prod4[37:24];
  end

  // what this position shows
  always_comb begin
    case (mode)
      MODE_STRING: begin
        ctl4_nxt.use_char  = length >= (3'(DIGITS) - {1'b0, lane_pos});
        ctl4_nxt.use_digit = 1'b0;
      end
      MODE_LABEL: begin
        ctl4_nxt.use_char  = length > {1'b0, lane_pos};
        ctl4_nxt.use_digit = !(length > {1'b0, lane_pos});
      end
      default: begin
        ctl4_nxt.use_char  = 1'b0;
        ctl4_nxt.use_digit = v >= lane_blank_limit(lane_pos);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q4_r   <= q4_nxt;
      ctl4_r <= ctl4_nxt;
      ch4_r  <= ch;
    end
  end

  // quotient by ten
  always_comb begin
    prod5  = 27'(q4_r) * 27'd6554;
    t5_nxt = prod5[25:16];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q5_r   <= q4_r;
      t5_r   <= t5_nxt;
      ctl5_r <= ctl4_r;
      ch5_r  <= ch4_r;
    end
  end

  // remainder is the digit, then encode
  always_comb begin
    diff  = q5_r - ({1'b0, t5_r, 3'b000} + {3'b000, t5_r, 1'b0});
    digit = diff[3:0];
    if (ctl5_r.use_char) begin
      seg = char_to_seg(ch5_r);
    end else if (ctl5_r.use_digit) begin
      seg = seg_pattern({2'b00, digit});
    end else begin
      seg = SEG_BLANK;
    end
  end

endmodule

`default_nettype wire

### rtl/ssdf_seq.sv
// merges the four lane results into five controller write beats
// depends on ssdf_pkg
`default_nettype none

module ssdf_seq
  import ssdf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load_valid,
  output logic            load_ready,
  input  wire seg_row_t   segs,
  input  wire logic [7:0] ctrl_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] out_command_byte,
  output logic      [7:0] out_data_byte,
  output logic            out_last_write
);

  seq_state_t state_r, state_nxt;
  seg_row_t   segs_r;

  assign load_ready = (state_r == SEQ_IDLE) || (state_r == SEQ_DIG3 && out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE: if (load_valid) state_nxt = SEQ_CTRL;
      SEQ_CTRL: if (out_ready) state_nxt = SEQ_DIG0;
      SEQ_DIG0: if (out_ready) state_nxt = SEQ_DIG1;
      SEQ_DIG1: if (out_ready) state_nxt = SEQ_DIG2;
      SEQ_DIG2: if (out_ready) state_nxt = SEQ_DIG3;
      SEQ_DIG3: begin
        if (out_ready) state_nxt = load_valid ? SEQ_CTRL : SEQ_IDLE;
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // hold the segment row for the item being sent
  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      segs_r <= segs;
    end
  end

  // beat contents, digit writes in controller order
  always_comb begin
    out_valid        = 1'b1;
    out_last_write   = 1'b0;
    out_command_byte = CMD_CONTROL;
    out_data_byte    = ctrl_byte;
    unique case (state_r)
      SEQ_IDLE: begin
        out_valid = 1'b0;
      end
      SEQ_CTRL: begin
        out_command_byte = CMD_CONTROL;
        out_data_byte    = ctrl_byte;
      end
      SEQ_DIG0: begin
        out_command_byte = CMD_DIG0;
        out_data_byte    = segs_r[3];
      end
      SEQ_DIG1: begin
        out_command_byte = CMD_DIG1;
        out_data_byte    = segs_r[0];
      end
      SEQ_DIG2: begin
        out_command_byte = CMD_DIG2;
        out_data_byte    = segs_r[1];
      end
      SEQ_DIG3: begin
        out_command_byte = CMD_DIG3;
        out_data_byte    = segs_r[2];
        out_last_write   = 1'b1;
      end
      default: begin
        out_valid = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/seven_segment_display_formatter.sv
// Four-digit seven-segment formatter: five controller write beats per item.
// An accepted item moves through the pipeline stages into the sequencer, which
// offers its five beats on consecutive cycles when the sink is ready. Items go
// out one at a time on the single result channel, while the pipeline takes more.
// Reset: brightness returns to 8 and the pipeline and sequencer empty.
// Depends on ssdf_pkg, ssdf_lane, ssdf_seq and the assertion macro header.
`default_nettype none
`include "seven_segment_display_formatter_macros.svh"

module seven_segment_display_formatter
  import ssdf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_brightness,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [31:0] in_value,
  input  wire logic [7:0]  in_char_0,
  input  wire logic [7:0]  in_char_1,
  input  wire logic [7:0]  in_char_2,
  input  wire logic [7:0]  in_char_3,
  input  wire logic [2:0]  in_length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [7:0]  out_command_byte,
  output logic      [7:0]  out_data_byte,
  output logic             out_last_write
);

  // residues of 2^16 and 2^24 modulo 10000, and 2^36 / 10000 rounded up
  localparam logic [21:0] RES_B2    = 22'd5536;
  localparam logic [21:0] RES_B3    = 22'd7216;
  localparam logic [22:0] RECIP_10K = 23'd6871948;
  localparam logic [13:0] DIV_10K   = 14'd10000;

  logic [3:0] bright_r;
  logic [7:0] ctrl_byte;

  logic       adv;
  logic       load_ready;
  seg_row_t   lane_segs;

  logic       s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r;

  logic [21:0] s1_sum_nxt, s1_sum_r;
  logic        s1_big_nxt, s1_big_r;
  logic [1:0]  s1_mode_r;
  logic [2:0]  s1_len_r;
  char_row_t   s1_chars_r;

  logic [44:0] s2_prod;
  logic [8:0]  s2_q_nxt, s2_q_r;
  logic [21:0] s2_sum_r;
  logic        s2_big_r;
  logic [1:0]  s2_mode_r;
  logic [2:0]  s2_len_r;
  char_row_t   s2_chars_r;

  logic [21:0] s3_rem;
  logic [13:0] s3_v_nxt, s3_v_r;
  logic [1:0]  s3_mode_r;
  logic [2:0]  s3_len_r;
  char_row_t   s3_chars_r;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      bright_r <= cfg_brightness;
    end
  end

  // display control byte
  always_comb begin
    if (bright_r == 4'd0) begin
      ctrl_byte = CTRL_OFF;
    end else if (bright_r > 4'd8) begin
      ctrl_byte = CTRL_ON;
    end else begin
      ctrl_byte = CTRL_ON | {bright_r, 4'b0000};
    end
  end

  // whole pipeline moves unless the last stage is held by the sequencer
  assign adv      = !s5_valid_r || load_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
    end
  end

  // stage 1: fold the value bytes into a small number with the same residue
  always_comb begin
    s1_sum_nxt = 22'(in_value[7:0]) + {6'd0, in_value[15:8], 8'h00}
               + 22'(in_value[23:16]) * RES_B2 + 22'(in_value[31:24]) * RES_B3;
    s1_big_nxt = in_value > 32'(NUM_MAX);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sum_r   <= s1_sum_nxt;
      s1_big_r   <= s1_big_nxt;
      s1_mode_r  <= in_mode;
      s1_len_r   <= in_length;
      s1_chars_r <= {in_char_3, in_char_2, in_char_1, in_char_0};
    end
  end

  // stage 2: quotient by 10000 through the reciprocal
  always_comb begin
    s2_prod  = 45'(s1_sum_r) * 45'(RECIP_10K);
    s2_q_nxt = s2_prod[44:36];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_q_r     <= s2_q_nxt;
      s2_sum_r   <= s1_sum_r;
      s2_big_r   <= s1_big_r;
      s2_mode_r  <= s1_mode_r;
      s2_len_r   <= s1_len_r;
      s2_chars_r <= s1_chars_r;
    end
  end

  // stage 3: residue modulo 10000, clamped in number mode
  always_comb begin
    s3_rem = s2_sum_r - 22'(s2_q_r * DIV_10K);
    if (s2_big_r && s2_mode_r != MODE_STRING && s2_mode_r != MODE_LABEL) begin
      s3_v_nxt = NUM_MAX;
    end else begin
      s3_v_nxt = s3_rem[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_v_r     <= s3_v_nxt;
      s3_mode_r  <= s2_mode_r;
      s3_len_r   <= s2_len_r;
      s3_chars_r <= s2_chars_r;
    end
  end

  // stages 4 and 5: one lane per display position
  for (genvar g = 0; g < DIGITS; g++) begin : g_lane
    ssdf_lane u_lane (
      .clk      (clk),
      .adv      (adv),
      .lane_pos (2'(g)),
      .mode     (s3_mode_r),
      .length   (s3_len_r),
      .v        (s3_v_r),
      .ch       (s3_chars_r[g]),
      .seg      (lane_segs[g])
    );
  end

  // merge into write beats
  ssdf_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .load_valid       (s5_valid_r),
    .load_ready       (load_ready),
    .segs             (lane_segs),
    .ctrl_byte        (ctrl_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_command_byte (out_command_byte),
    .out_data_byte    (out_data_byte),
    .out_last_write   (out_last_write)
  );

  // a control beat always opens the item after a last beat
  `SSDF_ASSERT_NXT(a_ctrl_after_last, clk, rst_n, out_valid && out_ready && out_last_write, !out_valid || out_command_byte == CMD_CONTROL, "item does not open with a control beat")
  // the five beats of an item are never broken by a gap
  `SSDF_ASSERT_NXT(a_no_gap, clk, rst_n, out_valid && out_ready && !out_last_write, out_valid, "gap inside an item")
  // a finished item with nothing queued leaves the channel idle
  `SSDF_ASSERT_NXT(a_drain, clk, rst_n, out_valid && out_ready && out_last_write && !s5_valid_r, !out_valid, "beat without an item")
  // input is stalled only while an item waits in the last stage and a beat is offered
  `SSDF_ASSERT_IMP(a_stall, clk, rst_n, !in_ready, s5_valid_r && out_valid, "input stalled with no pending item")

endmodule

`default_nettype wire
